>>> sv/lcd_mode_timing_sequencer_unit_assert.svh
// assertion macros for the lcd mode timing sequencer
// expects clk and rst_n in the scope of the module that uses them
`ifndef LCD_MODE_TIMING_SEQUENCER_UNIT_ASSERT_SVH
`define LCD_MODE_TIMING_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define LMTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// invariant that must hold at every clock edge out of reset
`define LMTS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

>>> sv/lmts_pkg.sv
// constants for the lcd mode timing sequencer
// no dependencies; imported by lcd_mode_timing_sequencer_unit
package lmts_pkg;

    // line timing
    localparam logic [9:0] DOTS_PER_LINE = 10'd456;
    localparam logic [9:0] OAM_DOTS      = 10'd80;
    localparam logic [9:0] XFER_DOTS     = 10'd172;
    localparam logic [9:0] XFER_END      = OAM_DOTS + XFER_DOTS;
    localparam logic [7:0] VISIBLE_LINES = 8'd144;
    localparam logic [7:0] LAST_LINE     = 8'd153;

    // mode codes
    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_OAM    = 2'd2;
    localparam logic [1:0] MODE_XFER   = 2'd3;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_LCD_ENABLE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_COMPARE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STAT_ENABLES = 2'd2;

    // status interrupt enable bit positions
    localparam int unsigned EN_HBLANK = 0;
    localparam int unsigned EN_VBLANK = 1;
    localparam int unsigned EN_OAM    = 2;
    localparam int unsigned EN_COIN   = 3;

    typedef logic [1:0] mode_t;

endpackage

>>> sv/lcd_mode_timing_sequencer_unit.sv
// lcd mode timing sequencer: dot counter, line counter and mode/interrupt pulses
// depends on lmts_pkg and lcd_mode_timing_sequencer_unit_assert.svh
//
// usage:
// - input channel (in_valid/in_ready, tick_count) carries the number of dot
//   clocks elapsed since the previous transfer
// - each input transfer yields exactly one result transfer on the output
//   channel (out_valid/out_ready): mode, current_line, coincidence and the
//   pulses vblank_irq, stat_irq, render_line, frame_done
// - an input transfer goes through the input register, one pass of add/compare
//   logic against the timing state and the result register, then result valid
// - throughput: one item per clock while the receiver is ready; the add/compare
//   path between the input register and the result register sets this figure
// - when the receiver stalls, the result register holds and the input
//   register takes one more item, then in_ready drops
// - configuration writes (cfg_write/cfg_index/cfg_data) take effect at once;
//   clearing lcd_enable zeroes line and dots and selects h-blank
// - reset clears the timing state, the configuration and both valid flags
`include "lcd_mode_timing_sequencer_unit_assert.svh"

module lcd_mode_timing_sequencer_unit
    import lmts_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write port
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input channel
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             tick_count,
    // output channel
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             mode,
    output logic [7:0]             current_line,
    output logic                   coincidence,
    output logic                   vblank_irq,
    output logic                   stat_irq,
    output logic                   render_line,
    output logic                   frame_done
);

    // configuration registers
    logic       lcd_enable_reg;
    logic [7:0] line_compare_reg;
    logic [3:0] stat_en_reg;

    // timing state
    logic [8:0] dot_count_reg, dot_count_next;
    logic [7:0] line_reg, line_next;
    mode_t      mode_reg, mode_next;
    logic       coin_reg, coin_next;

    // pipeline registers
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] tick_reg;
    logic       out_valid_reg, out_valid_next;
    mode_t      out_mode_reg;
    logic [7:0] out_line_reg;
    logic       out_coin_reg;
    logic       out_vblank_reg;
    logic       out_stat_reg;
    logic       out_render_reg;
    logic       out_frame_reg;

    // combinational step results
    logic [9:0] dots_sum;
    logic [9:0] dots_wrap;
    logic [8:0] line_inc;
    logic       mode_entered;
    logic       line_changed;
    logic       coin_hit;
    logic       mode_req;
    logic       vblank_pulse;
    logic       render_pulse;
    logic       frame_pulse;
    logic       stat_pulse;
    logic       advance;
    logic       lcd_off_write;

    // handshake control
    assign advance        = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready       = !s1_valid_reg || advance;
    assign s1_valid_next  = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // one step of the dot/line/mode sequencer
    always_comb
    begin
        dots_sum       = {1'b0, dot_count_reg} + {2'b00, tick_reg};
        dots_wrap      = dots_sum - DOTS_PER_LINE;
        line_inc       = {1'b0, line_reg} + 9'd1;
        dot_count_next = dot_count_reg;
        line_next      = line_reg;
        mode_next      = mode_reg;
        mode_entered   = 1'b0;
        line_changed   = 1'b0;
        vblank_pulse   = 1'b0;
        render_pulse   = 1'b0;
        frame_pulse    = 1'b0;
        if (lcd_enable_reg)
        begin
            dot_count_next = dots_sum[8:0];
            if (line_reg < VISIBLE_LINES)
            begin
                if (dots_sum < OAM_DOTS)
                begin
                    if (mode_reg != MODE_OAM)
                    begin
                        mode_next    = MODE_OAM;
                        mode_entered = 1'b1;
                    end
                end
                else if (dots_sum < XFER_END)
                begin
                    mode_next = MODE_XFER;
                end
                else if (dots_sum < DOTS_PER_LINE)
                begin
                    if (mode_reg != MODE_HBLANK)
                    begin
                        mode_next    = MODE_HBLANK;
                        mode_entered = 1'b1;
                        render_pulse = 1'b1;
                    end
                end
                else
                begin
                    dot_count_next = dots_wrap[8:0];
                    line_next      = line_inc[7:0];
                    line_changed   = 1'b1;
                    mode_entered   = 1'b1;
                    if (line_inc[7:0] == VISIBLE_LINES)
                    begin
                        mode_next    = MODE_VBLANK;
                        vblank_pulse = 1'b1;
                        frame_pulse  = 1'b1;
                    end
                    else
                    begin
                        mode_next = MODE_OAM;
                    end
                end
            end
            else if (dots_sum >= DOTS_PER_LINE)
            begin
                dot_count_next = dots_wrap[8:0];
                line_changed   = 1'b1;
                if (line_inc > {1'b0, LAST_LINE})
                begin
                    line_next    = '0;
                    mode_next    = MODE_OAM;
                    mode_entered = 1'b1;
                end
                else
                begin
                    line_next = line_inc[7:0];
                end
            end
        end
    end

    // coincidence and status interrupt request
    assign coin_hit  = (line_next == line_compare_reg);
    assign coin_next = line_changed ? coin_hit : coin_reg;
    assign mode_req  = (stat_en_reg[EN_COIN]   && coin_hit)
                    || (stat_en_reg[EN_OAM]    && mode_next == MODE_OAM)
                    || (stat_en_reg[EN_VBLANK] && mode_next == MODE_VBLANK)
                    || (stat_en_reg[EN_HBLANK] && mode_next == MODE_HBLANK);
    assign stat_pulse = (mode_entered && mode_req)
                     || (line_changed && coin_hit && stat_en_reg[EN_COIN]);

    // display-off write clears the timing state
    assign lcd_off_write = cfg_write && (cfg_index == REG_LCD_ENABLE)
                        && lcd_enable_reg && !cfg_data[0];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcd_enable_reg   <= 1'b0;
            line_compare_reg <= '0;
            stat_en_reg      <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_LCD_ENABLE:   lcd_enable_reg   <= cfg_data[0];
                REG_LINE_COMPARE: line_compare_reg <= cfg_data;
                REG_STAT_ENABLES: stat_en_reg      <= cfg_data[3:0];
                default:          ;
            endcase
        end
    end

    // timing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_count_reg <= '0;
            line_reg      <= '0;
            mode_reg      <= MODE_HBLANK;
            coin_reg      <= 1'b0;
        end
        else if (lcd_off_write)
        begin
            dot_count_reg <= '0;
            line_reg      <= '0;
            mode_reg      <= MODE_HBLANK;
        end
        else if (advance)
        begin
            dot_count_reg <= dot_count_next;
            line_reg      <= line_next;
            mode_reg      <= mode_next;
            coin_reg      <= coin_next;
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input payload register
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            tick_reg <= tick_count;
        end
    end

    // result payload register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_mode_reg   <= mode_next;
            out_line_reg   <= line_next;
            out_coin_reg   <= coin_next;
            out_vblank_reg <= vblank_pulse;
            out_stat_reg   <= stat_pulse;
            out_render_reg <= render_pulse;
            out_frame_reg  <= frame_pulse;
        end
    end

    // output ports
    assign out_valid    = out_valid_reg;
    assign mode         = out_mode_reg;
    assign current_line = out_line_reg;
    assign coincidence  = out_coin_reg;
    assign vblank_irq   = out_vblank_reg;
    assign stat_irq     = out_stat_reg;
    assign render_line  = out_render_reg;
    assign frame_done   = out_frame_reg;

    // checks
    `LMTS_ASSERT_ALWAYS(a_dots_in_line, ({1'b0, dot_count_reg} < DOTS_PER_LINE),
        "dot counter reached a full line")
    `LMTS_ASSERT_ALWAYS(a_line_in_range, line_reg <= LAST_LINE,
        "line counter past the last line")
    `LMTS_ASSERT_NOW(a_vblank_entry, out_valid && vblank_irq,
        current_line == VISIBLE_LINES && mode == MODE_VBLANK,
        "vblank pulse away from the first vblank line")
    `LMTS_ASSERT_NOW(a_render_visible, out_valid && render_line,
        current_line < VISIBLE_LINES && mode == MODE_HBLANK,
        "render request outside visible hblank")
    `LMTS_ASSERT_NOW(a_frame_with_vblank, out_valid && frame_done, vblank_irq,
        "frame done without vblank pulse")

endmodule
